>>> hw/rtl/lru_element_cache_directory_unit_defines.svh
// Assertion macros for the LRU element cache directory.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef LRU_ELEMENT_CACHE_DIRECTORY_UNIT_DEFINES_SVH
`define LRU_ELEMENT_CACHE_DIRECTORY_UNIT_DEFINES_SVH

// cond must hold at every clock edge out of reset
`define LECD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons must hold at the same edge where ante holds
`define LECD_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/lecd_pkg.sv
// Shared types and constants for the LRU element cache directory.
// No dependencies.
`timescale 1ns / 1ps

package lecd_pkg;

    localparam int ELEM_COUNT_W = 21;
    localparam int CAPACITY_W   = 5;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 21;

    // config register map
    localparam logic [CFG_INDEX_W-1:0] CFG_ELEMENT_COUNT = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY      = CFG_INDEX_W'(1);

    localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = CAPACITY_W'(16);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    // flags carried by the search packet along the cell chain
    typedef struct packed {
        logic valid;
        logic found;
        logic free_found;
        logic victim_found;
    } srch_flags_t;

    // broadcast update command
    typedef struct packed {
        logic en;
        logic alloc;
    } upd_ctl_t;

endpackage

>>> hw/rtl/lru_element_cache_directory_unit.sv
// Top level of the LRU element cache directory: FSM, config registers,
// result register and the chain of lecd_cell. Depends on lecd_pkg and the
// defines header.
`timescale 1ns / 1ps
// Usage
//   Access channel (in_valid/in_ready, mode, index): one get (mode 0) or put
//   (mode 1) transaction; in_ready is high only while the directory is idle.
//   Result channel (out_valid/out_ready): one result transaction per access,
//   held in an output register until taken.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): register 0 is
//   element_count, register 1 is capacity; cfg_ready is always high. Write
//   only while no access is outstanding.
// Access flow
//   An in-range access walks a search packet through the ENTRIES cells, one
//   cell per cycle, then the finish state loads the result register and
//   updates the ranks; the next access is taken once the directory is back
//   in idle, so one access is in flight at a time, paced by the chain
//   length. An out-of-range access goes straight to the finish state.
// Reset: all slots invalid, occupancy zero, element_count 0 (every access out
//   of range until written), capacity 16.
// Back-pressure: a new access may be accepted while a result waits; the next
//   result then holds in the finish state, slots untouched, until it can be
//   registered.

`include "lru_element_cache_directory_unit_defines.svh"

module lru_element_cache_directory_unit #(
    parameter int ENTRIES    = 16,
    parameter int INDEX_BITS = 20,
    localparam int SLOT_W    = $clog2(ENTRIES)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // access channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             mode,
    input  logic [INDEX_BITS-1:0]            index,
    // result channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             status,
    output logic                             hit,
    output logic [SLOT_W-1:0]                slot,
    output logic                             fill_needed,
    output logic                             evict_valid,
    output logic [INDEX_BITS-1:0]            evicted_index,
    output logic                             write_through,
    // config channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lecd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lecd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lecd_pkg::*;

    localparam int RANK_W = $clog2(ENTRIES);
    localparam int OCC_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (INDEX_BITS > ELEM_COUNT_W) ? INDEX_BITS : ELEM_COUNT_W;

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    state_t                  state_reg, state_next;
    logic [ELEM_COUNT_W-1:0] element_count_reg, element_count_next;
    logic [CAPACITY_W-1:0]   capacity_reg, capacity_next;
    logic [OCC_W-1:0]        occupancy_reg, occupancy_next;

    logic                    req_mode_reg;
    logic [INDEX_BITS-1:0]   req_idx_reg;
    logic                    req_oor_reg;

    // result register
    logic                    out_valid_reg, out_valid_next;
    logic                    status_reg, hit_reg, fill_reg, evict_reg, wt_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic [INDEX_BITS-1:0]   evicted_reg;

    // ------------------------------------------------------------------
    // cell chain: element k feeds cell k, element ENTRIES is the tail
    // ------------------------------------------------------------------
    srch_flags_t             ch_flags        [0:ENTRIES];
    logic [INDEX_BITS-1:0]   ch_idx          [0:ENTRIES];
    logic [SLOT_W-1:0]       ch_found_slot   [0:ENTRIES];
    logic [RANK_W-1:0]       ch_found_rank   [0:ENTRIES];
    logic [SLOT_W-1:0]       ch_free_slot    [0:ENTRIES];
    logic [RANK_W-1:0]       ch_victim_rank  [0:ENTRIES];
    logic [SLOT_W-1:0]       ch_victim_slot  [0:ENTRIES];
    logic [INDEX_BITS-1:0]   ch_victim_index [0:ENTRIES];

    upd_ctl_t                upd;
    logic [SLOT_W-1:0]       upd_slot;
    logic [OCC_W-1:0]        upd_rank;

    // handshake / control
    logic in_fire;
    logic in_oor;
    logic in_search;
    logic finishing;
    logic out_load;
    logic [OCC_W-1:0] occ_m1;
    logic [OCC_W-1:0] eff_cap;

    // decision on the packet at the chain tail
    logic tail_found;
    logic miss_get;
    logic do_evict;
    logic do_fill;

    // in-range eviction / fill about to finish
    logic chk_evict;
    logic chk_fill;

    assign in_fire   = in_valid && in_ready;
    assign in_oor    = CMP_W'(index) >= CMP_W'(element_count_reg);
    assign in_search = in_fire && !in_oor;
    assign occ_m1    = occupancy_reg - OCC_W'(1);

    // capacity 0 acts as 1, above ENTRIES acts as ENTRIES
    always_comb
    begin
        if (capacity_reg == '0)
            eff_cap = OCC_W'(1);
        else if (int'(capacity_reg) > ENTRIES)
            eff_cap = OCC_W'(ENTRIES);
        else
            eff_cap = OCC_W'(capacity_reg);
    end

    // chain head: packet enters cell 0 at acceptance
    always_comb
    begin
        ch_flags[0]        = '0;
        ch_flags[0].valid  = in_search;
        ch_idx[0]          = index;
        ch_found_slot[0]   = '0;
        ch_found_rank[0]   = '0;
        ch_free_slot[0]    = '0;
        ch_victim_rank[0]  = occ_m1[RANK_W-1:0];
        ch_victim_slot[0]  = '0;
        ch_victim_index[0] = '0;
    end

    for (genvar k = 0; k < ENTRIES; k++)
    begin : g_cell
        lecd_cell #(
            .ENTRIES    (ENTRIES),
            .INDEX_BITS (INDEX_BITS),
            .CELL_ID    (k)
        ) u_cell (
            .clk              (clk),
            .rst_n            (rst_n),
            .in_flags         (ch_flags[k]),
            .in_idx           (ch_idx[k]),
            .in_found_slot    (ch_found_slot[k]),
            .in_found_rank    (ch_found_rank[k]),
            .in_free_slot     (ch_free_slot[k]),
            .in_victim_rank   (ch_victim_rank[k]),
            .in_victim_slot   (ch_victim_slot[k]),
            .in_victim_index  (ch_victim_index[k]),
            .out_flags        (ch_flags[k+1]),
            .out_idx          (ch_idx[k+1]),
            .out_found_slot   (ch_found_slot[k+1]),
            .out_found_rank   (ch_found_rank[k+1]),
            .out_free_slot    (ch_free_slot[k+1]),
            .out_victim_rank  (ch_victim_rank[k+1]),
            .out_victim_slot  (ch_victim_slot[k+1]),
            .out_victim_index (ch_victim_index[k+1]),
            .upd              (upd),
            .upd_slot         (upd_slot),
            .upd_rank         (upd_rank),
            .upd_idx          (req_idx_reg)
        );
    end

    // ------------------------------------------------------------------
    // FSM
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = in_oor ? ST_FINISH : ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (ch_flags[ENTRIES].valid)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        finishing = 1'b0;
        unique case (state_reg)
            ST_IDLE:   in_ready  = 1'b1;
            ST_SEARCH: in_ready  = 1'b0;
            ST_FINISH: finishing = 1'b1;
            default:   in_ready  = 1'b0;
        endcase
    end

    assign out_load = finishing && (!out_valid_reg || out_ready);

    // ------------------------------------------------------------------
    // access decision; victim is the valid slot ranked occupancy-1
    // ------------------------------------------------------------------
    assign tail_found = ch_flags[ENTRIES].found;
    assign miss_get   = !tail_found && !req_mode_reg;
    assign do_evict   = miss_get && (occupancy_reg >= eff_cap);
    assign do_fill    = miss_get && !do_evict;

    always_comb
    begin
        upd.en    = out_load && !req_oor_reg && (tail_found || miss_get);
        upd.alloc = miss_get;
        if (tail_found)
        begin
            upd_slot = ch_found_slot[ENTRIES];
            upd_rank = OCC_W'(ch_found_rank[ENTRIES]);
        end
        else if (do_evict)
        begin
            upd_slot = ch_victim_slot[ENTRIES];
            upd_rank = occ_m1;
        end
        else
        begin
            // fill: every valid rank ages
            upd_slot = ch_free_slot[ENTRIES];
            upd_rank = occupancy_reg;
        end
    end

    always_comb
    begin
        occupancy_next = occupancy_reg;
        if (out_load && !req_oor_reg && do_fill)
            occupancy_next = occupancy_reg + OCC_W'(1);
    end

    // ------------------------------------------------------------------
    // config writes
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_comb
    begin
        element_count_next = element_count_reg;
        capacity_next      = capacity_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ELEMENT_COUNT: element_count_next = cfg_data[ELEM_COUNT_W-1:0];
                CFG_CAPACITY:      capacity_next      = cfg_data[CAPACITY_W-1:0];
                default:           ;
            endcase
        end
    end

    assign out_valid_next = out_load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            element_count_reg <= '0;
            capacity_reg      <= CAPACITY_RESET;
            occupancy_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            element_count_reg <= element_count_next;
            capacity_reg      <= capacity_next;
            occupancy_reg     <= occupancy_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_mode_reg <= mode;
            req_idx_reg  <= index;
            req_oor_reg  <= in_oor;
        end
        if (out_load)
        begin
            status_reg  <= req_oor_reg;
            hit_reg     <= !req_oor_reg && tail_found;
            slot_reg    <= (!req_oor_reg && (tail_found || miss_get)) ? upd_slot : '0;
            fill_reg    <= !req_oor_reg && miss_get;
            evict_reg   <= !req_oor_reg && do_evict;
            evicted_reg <= (!req_oor_reg && do_evict) ? ch_victim_index[ENTRIES] : '0;
            wt_reg      <= !req_oor_reg && req_mode_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign hit           = hit_reg;
    assign slot          = slot_reg;
    assign fill_needed   = fill_reg;
    assign evict_valid   = evict_reg;
    assign evicted_index = evicted_reg;
    assign write_through = wt_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    assign chk_evict = finishing && !req_oor_reg && do_evict;
    assign chk_fill  = finishing && !req_oor_reg && do_fill;

    `LECD_ASSERT_ALWAYS(a_occ_bound, occupancy_reg <= OCC_W'(ENTRIES), "occupancy above ENTRIES")
    `LECD_ASSERT_IMPLIES(a_victim_seen, chk_evict, ch_flags[ENTRIES].victim_found, "no victim")
    `LECD_ASSERT_IMPLIES(a_free_seen, chk_fill, ch_flags[ENTRIES].free_found, "no free slot")
    `LECD_ASSERT_IMPLIES(a_hit_no_fill, out_valid_reg, !(hit_reg && fill_reg), "hit and fill")

endmodule

>>> hw/rtl/lecd_cell.sv
// One directory cell: holds one slot (valid, index, recency rank) and one
// stage of the search packet. Depends on lecd_pkg.
`timescale 1ns / 1ps

module lecd_cell #(
    parameter int ENTRIES    = 16,
    parameter int INDEX_BITS = 20,
    parameter int CELL_ID    = 0,
    localparam int SLOT_W    = $clog2(ENTRIES),
    localparam int RANK_W    = $clog2(ENTRIES),
    localparam int OCC_W     = $clog2(ENTRIES + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // search packet in
    input  lecd_pkg::srch_flags_t    in_flags,
    input  logic [INDEX_BITS-1:0]    in_idx,
    input  logic [SLOT_W-1:0]        in_found_slot,
    input  logic [RANK_W-1:0]        in_found_rank,
    input  logic [SLOT_W-1:0]        in_free_slot,
    input  logic [RANK_W-1:0]        in_victim_rank,
    input  logic [SLOT_W-1:0]        in_victim_slot,
    input  logic [INDEX_BITS-1:0]    in_victim_index,
    // search packet out
    output lecd_pkg::srch_flags_t    out_flags,
    output logic [INDEX_BITS-1:0]    out_idx,
    output logic [SLOT_W-1:0]        out_found_slot,
    output logic [RANK_W-1:0]        out_found_rank,
    output logic [SLOT_W-1:0]        out_free_slot,
    output logic [RANK_W-1:0]        out_victim_rank,
    output logic [SLOT_W-1:0]        out_victim_slot,
    output logic [INDEX_BITS-1:0]    out_victim_index,
    // update broadcast
    input  lecd_pkg::upd_ctl_t       upd,
    input  logic [SLOT_W-1:0]        upd_slot,
    input  logic [OCC_W-1:0]         upd_rank,
    input  logic [INDEX_BITS-1:0]    upd_idx
);
    import lecd_pkg::*;

    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(CELL_ID);

    // slot state
    logic                  valid_reg, valid_next;
    logic [INDEX_BITS-1:0] index_reg, index_next;
    logic [RANK_W-1:0]     rank_reg, rank_next;

    // packet stage
    srch_flags_t           flags_reg, flags_next;
    logic [INDEX_BITS-1:0] idx_reg;
    logic [SLOT_W-1:0]     found_slot_reg, found_slot_next;
    logic [RANK_W-1:0]     found_rank_reg, found_rank_next;
    logic [SLOT_W-1:0]     free_slot_reg, free_slot_next;
    logic [RANK_W-1:0]     victim_rank_reg;
    logic [SLOT_W-1:0]     victim_slot_reg, victim_slot_next;
    logic [INDEX_BITS-1:0] victim_index_reg, victim_index_next;

    logic hit_here;
    logic is_target;

    assign hit_here  = valid_reg && (index_reg == in_idx);
    assign is_target = upd.en && (upd_slot == MY_SLOT);

    // packet: first match, first free slot, slot holding the victim rank
    always_comb
    begin
        flags_next        = in_flags;
        found_slot_next   = in_found_slot;
        found_rank_next   = in_found_rank;
        free_slot_next    = in_free_slot;
        victim_slot_next  = in_victim_slot;
        victim_index_next = in_victim_index;
        if (in_flags.valid)
        begin
            if (hit_here && !in_flags.found)
            begin
                flags_next.found = 1'b1;
                found_slot_next  = MY_SLOT;
                found_rank_next  = rank_reg;
            end
            if (!valid_reg && !in_flags.free_found)
            begin
                flags_next.free_found = 1'b1;
                free_slot_next        = MY_SLOT;
            end
            if (valid_reg && (rank_reg == in_victim_rank) && !in_flags.victim_found)
            begin
                flags_next.victim_found = 1'b1;
                victim_slot_next        = MY_SLOT;
                victim_index_next       = index_reg;
            end
        end
        else
        begin
            // hold the last packet, drop only its valid
            flags_next       = flags_reg;
            flags_next.valid = 1'b0;
        end
    end

    // slot update
    always_comb
    begin
        valid_next = valid_reg;
        index_next = index_reg;
        rank_next  = rank_reg;
        if (is_target)
        begin
            rank_next = '0;
            if (upd.alloc)
            begin
                valid_next = 1'b1;
                index_next = upd_idx;
            end
        end
        else if (upd.en && valid_reg && (OCC_W'(rank_reg) < upd_rank))
        begin
            rank_next = rank_reg + RANK_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
            flags_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        index_reg <= index_next;
        if (in_flags.valid)
        begin
            idx_reg          <= in_idx;
            found_slot_reg   <= found_slot_next;
            found_rank_reg   <= found_rank_next;
            free_slot_reg    <= free_slot_next;
            victim_rank_reg  <= in_victim_rank;
            victim_slot_reg  <= victim_slot_next;
            victim_index_reg <= victim_index_next;
        end
    end

    assign out_flags        = flags_reg;
    assign out_idx          = idx_reg;
    assign out_found_slot   = found_slot_reg;
    assign out_found_rank   = found_rank_reg;
    assign out_free_slot    = free_slot_reg;
    assign out_victim_rank  = victim_rank_reg;
    assign out_victim_slot  = victim_slot_reg;
    assign out_victim_index = victim_index_reg;

endmodule

>>> verif/tb_lru_element_cache_directory_unit.sv
// Self-checking testbench for lru_element_cache_directory_unit: directed table, then random
// phases under random idling; results checked against an LRU model or a typed-in answer.
// Depends on lecd_pkg and the unit RTL.
`timescale 1ns / 1ps

module tb_lru_element_cache_directory_unit;

    localparam int ENTRIES    = 16;
    localparam int INDEX_BITS = 20;
    localparam int SLOT_W     = $clog2(ENTRIES);

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    localparam logic STATUS_OK           = 1'b0;
    localparam logic STATUS_OUT_OF_RANGE = 1'b1;

    // register index with nothing behind it; a write there must change nothing
    localparam logic [lecd_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED = lecd_pkg::CFG_INDEX_W'(3);

    localparam int RANDOM_PHASES    = 10;
    localparam int ITEMS_PER_PHASE  = 113;
    localparam int IDLE_PERCENT     = 32;
    localparam int PUT_PERCENT      = 35;
    localparam int HOLD_EVERY       = 450;   // results between long receiver hold-offs
    localparam int HOLD_CYCLES      = 300;

    // one result transaction, in port order
    typedef struct packed {
        logic                  status;
        logic                  hit;
        logic [SLOT_W-1:0]     slot;
        logic                  fill_needed;
        logic                  evict_valid;
        logic [INDEX_BITS-1:0] evicted_index;
        logic                  write_through;
    } dir_result_t;

    // one row of the directed table: either a register write or an access
    typedef struct {
        bit                           is_cfg;
        logic [lecd_pkg::CFG_INDEX_W-1:0] reg_sel;
        logic [lecd_pkg::CFG_DATA_W-1:0]  reg_data;
        logic                         m;
        logic [INDEX_BITS-1:0]        idx;
        bit                           pinned;
        dir_result_t                  want;
    } plan_row_t;

    // ------------------------------------------------------------------
    // DUT signals; every input known from time zero
    // ------------------------------------------------------------------
    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             in_valid = 1'b0;
    logic                             in_ready;
    logic                             mode = MODE_GET;
    logic [INDEX_BITS-1:0]            index = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic                             status;
    logic                             hit;
    logic [SLOT_W-1:0]                slot;
    logic                             fill_needed;
    logic                             evict_valid;
    logic [INDEX_BITS-1:0]            evicted_index;
    logic                             write_through;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [lecd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [lecd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    lru_element_cache_directory_unit #(
        .ENTRIES    (ENTRIES),
        .INDEX_BITS (INDEX_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .index         (index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .hit           (hit),
        .slot          (slot),
        .fill_needed   (fill_needed),
        .evict_valid   (evict_valid),
        .evicted_index (evicted_index),
        .write_through (write_through),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Directory model: tags, valid bits, recency ages (0 = most recent),
    // occupancy and our own copy of the two registers.
    // ------------------------------------------------------------------
    logic [INDEX_BITS-1:0]           line_tag   [ENTRIES];
    bit                              line_valid [ENTRIES];
    int unsigned                     line_age   [ENTRIES];
    int unsigned                     lines_used = 0;
    logic [lecd_pkg::ELEM_COUNT_W-1:0] cfg_elem_count = '0;
    logic [lecd_pkg::CAPACITY_W-1:0]   cfg_capacity   = lecd_pkg::CAPACITY_RESET;

    initial
    begin
        for (int k = 0; k < ENTRIES; k++)
        begin
            line_tag[k]   = '0;
            line_valid[k] = 1'b0;
            line_age[k]   = 0;
        end
    end

    // line s becomes most recent; valid lines newer than its old age grow one older
    function automatic void promote_line(input int s, input int unsigned old_age);
        for (int k = 0; k < ENTRIES; k++)
            if (line_valid[k] && k != s && line_age[k] < old_age)
                line_age[k]++;
        line_age[s] = 0;
    endfunction

    function automatic dir_result_t predict_access(input logic m, input logic [INDEX_BITS-1:0] idx);
        dir_result_t r;
        int          found;
        int          target;
        int unsigned worst;
        int unsigned eff;
        r      = '0;
        found  = -1;
        target = -1;
        if ({1'b0, idx} >= cfg_elem_count)
        begin
            r.status = STATUS_OUT_OF_RANGE;
            return r;
        end
        r.status = STATUS_OK;
        for (int k = 0; k < ENTRIES; k++)
            if (found < 0 && line_valid[k] && line_tag[k] == idx)
                found = k;
        if (found >= 0)
        begin
            promote_line(found, line_age[found]);
            r.hit           = 1'b1;
            r.slot          = SLOT_W'(found);
            r.write_through = (m == MODE_PUT);
            return r;
        end
        // put miss: write through only, nothing allocated
        if (m == MODE_PUT)
        begin
            r.write_through = 1'b1;
            return r;
        end
        // get miss; capacity 0 acts as 1, anything above ENTRIES as ENTRIES
        eff = (cfg_capacity == 0) ? 1 : (cfg_capacity > ENTRIES) ? ENTRIES : cfg_capacity;
        if (lines_used >= eff)
        begin
            worst = 0;
            for (int k = 0; k < ENTRIES; k++)
                if (line_valid[k] && (target < 0 || line_age[k] > worst))
                begin
                    target = k;
                    worst  = line_age[k];
                end
            if (target >= 0)
            begin
                r.evict_valid    = 1'b1;
                r.evicted_index  = line_tag[target];
                line_tag[target] = idx;
                promote_line(target, worst);
            end
        end
        if (target < 0)
        begin
            for (int k = 0; k < ENTRIES; k++)
                if (target < 0 && !line_valid[k])
                    target = k;
            for (int k = 0; k < ENTRIES; k++)
                if (line_valid[k])
                    line_age[k]++;
            line_valid[target] = 1'b1;
            line_tag[target]   = idx;
            line_age[target]   = 0;
            lines_used++;
        end
        r.slot        = SLOT_W'(target);
        r.fill_needed = 1'b1;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard. Expectations are queued at input acceptance and popped
    // at output acceptance. Directed rows with a typed-in answer ride along
    // with the payload (pin_on/pin_want) and replace the model's answer.
    // ------------------------------------------------------------------
    dir_result_t pending_results[$];
    logic        pin_on = 1'b0;
    dir_result_t pin_want = '0;
    int          n_results = 0;      // updated with NBA so the stimulus reads it race-free
    int          n_fail = 0;
    int          n_hits = 0;
    int          n_fills = 0;
    int          n_evicts = 0;
    int          n_puts = 0;
    int          n_oor = 0;

    task automatic compare_field(input string name, input logic [31:0] e, input logic [31:0] a);
        if (e !== a)
        begin
            n_fail++;
            if (n_fail <= 10)
                $display("[%0t] result %0d: %s expected %0h got %0h", $realtime, n_results,
                         name, e, a);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        dir_result_t got;
        dir_result_t want;
        if (rst_n)
        begin
            // register writes land in our copy at the same edge as in the DUT
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == lecd_pkg::CFG_ELEMENT_COUNT)
                    cfg_elem_count = cfg_data[lecd_pkg::ELEM_COUNT_W-1:0];
                else if (cfg_index == lecd_pkg::CFG_CAPACITY)
                    cfg_capacity = cfg_data[lecd_pkg::CAPACITY_W-1:0];
            end
            if (out_valid && out_ready)
            begin
                got = '{status, hit, slot, fill_needed, evict_valid, evicted_index,
                        write_through};
                if (pending_results.size() == 0)
                begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("[%0t] result with nothing outstanding: %p", $realtime, got);
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("status", 32'(want.status), 32'(got.status));
                    compare_field("hit", 32'(want.hit), 32'(got.hit));
                    compare_field("slot", 32'(want.slot), 32'(got.slot));
                    compare_field("fill_needed", 32'(want.fill_needed), 32'(got.fill_needed));
                    compare_field("evict_valid", 32'(want.evict_valid), 32'(got.evict_valid));
                    compare_field("evicted_index", 32'(want.evicted_index),
                                  32'(got.evicted_index));
                    compare_field("write_through", 32'(want.write_through),
                                  32'(got.write_through));
                end
                n_results <= n_results + 1;
            end
            if (in_valid && in_ready)
            begin
                want = predict_access(mode, index);
                n_hits   += want.hit;
                n_fills  += want.fill_needed;
                n_evicts += want.evict_valid;
                n_oor    += want.status;
                n_puts   += (mode == MODE_PUT);
                if (pin_on)
                    want = pin_want;
                pending_results.push_back(want);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, none during the calm stretch, and
    // every HOLD_EVERY results a long hold-off so the block backs up and
    // drops in_ready while the sender keeps offering.
    // ------------------------------------------------------------------
    logic calm = 1'b0;
    int   n_taken = 0;
    int   hold_left = 0;

    always @(posedge clk)
    begin : drain_results
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                n_taken++;
                if (n_taken % HOLD_EVERY == 0)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    int n_sent = 0;
    int n_writes = 0;

    // Offer one access and return at the edge it is taken. in_valid is left
    // high so a back-to-back access keeps it up without a dip.
    task automatic issue_access(input logic m, input logic [INDEX_BITS-1:0] idx, input bit pin,
                                input dir_result_t want);
        if (cfg_valid)
            cfg_valid <= 1'b0;
        if (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2 * ENTRIES)) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        index    <= idx;
        pin_on   <= pin;
        pin_want <= want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n_sent++;
    endtask

    // Register writes only go out with the directory idle: every result back.
    task automatic write_reg(input logic [lecd_pkg::CFG_INDEX_W-1:0] sel,
                             input logic [lecd_pkg::CFG_DATA_W-1:0] data);
        if (in_valid)
            in_valid <= 1'b0;
        while (n_results != n_sent)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        n_writes++;
    endtask

    // directed table
    plan_row_t access_plan[$];

    function automatic dir_result_t make_result(input logic st, input logic h,
                                                input logic [SLOT_W-1:0] sl, input logic f,
                                                input logic ev, input logic [INDEX_BITS-1:0] ei,
                                                input logic wt);
        make_result = '{st, h, sl, f, ev, ei, wt};
    endfunction

    task automatic plan_write(input logic [lecd_pkg::CFG_INDEX_W-1:0] sel,
                              input logic [lecd_pkg::CFG_DATA_W-1:0] data);
        plan_row_t row;
        row          = '{default: '0};
        row.is_cfg   = 1'b1;
        row.reg_sel  = sel;
        row.reg_data = data;
        access_plan.push_back(row);
    endtask

    task automatic plan_access(input logic m, input logic [INDEX_BITS-1:0] idx, input bit pin,
                               input dir_result_t want);
        plan_row_t row;
        row        = '{default: '0};
        row.m      = m;
        row.idx    = idx;
        row.pinned = pin;
        row.want   = want;
        access_plan.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    int unsigned phase_ec  [RANDOM_PHASES] = '{21'h100000, 24, 21'h1FFFFF, 5000, 1,
                                               21'h0FFFFF, 0, 40, 21'h080000, 300};
    int unsigned phase_cap [RANDOM_PHASES] = '{16, 1, 0, 4, 31, 2, 8, 16, 3, 12};

    initial
    begin : stimulus
        dir_result_t                     out_of_range;
        dir_result_t                     none;
        logic [INDEX_BITS-1:0]           idx;
        logic [lecd_pkg::CFG_DATA_W-1:0] cap_word;
        int                              pick;
        int                              eff;
        int                              span;
        int                              pool_n;
        int                              base;

        out_of_range = make_result(STATUS_OUT_OF_RANGE, 1'b0, '0, 1'b0, 1'b0, '0, 1'b0);
        none         = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // After reset element_count is 0: everything is out of range.
        plan_access(MODE_GET, '0, 1'b1, out_of_range);
        plan_access(MODE_PUT, '1, 1'b1, out_of_range);
        // Every data bit high: all indices in range.
        plan_write(lecd_pkg::CFG_ELEMENT_COUNT, '1);
        // Capacity field 0 with junk above it; acts as a capacity of one.
        plan_write(lecd_pkg::CFG_CAPACITY, 21'h1FFFE0);
        plan_access(MODE_GET, '1, 1'b1,
                    make_result(STATUS_OK, 1'b0, '0, 1'b1, 1'b0, '0, 1'b0));
        plan_access(MODE_GET, '0, 1'b1,
                    make_result(STATUS_OK, 1'b0, '0, 1'b1, 1'b1, '1, 1'b0));
        plan_access(MODE_PUT, '0, 1'b1,
                    make_result(STATUS_OK, 1'b1, '0, 1'b0, 1'b0, '0, 1'b1));
        plan_access(MODE_PUT, 20'h12345, 1'b1,
                    make_result(STATUS_OK, 1'b0, '0, 1'b0, 1'b0, '0, 1'b1));
        // Capacity above ENTRIES; fill every slot, then miss once more at full.
        plan_write(lecd_pkg::CFG_CAPACITY, 21'd31);
        for (int k = 1; k < ENTRIES; k++)
            plan_access(MODE_GET, 20'(20'h11111 * k), 1'b0, none);
        plan_access(MODE_GET, 20'h54321, 1'b0, none);
        plan_access(MODE_PUT, 20'h22222, 1'b0, none);
        // Capacity dropped below the occupancy: misses keep evicting.
        plan_write(lecd_pkg::CFG_CAPACITY, 21'd2);
        plan_access(MODE_GET, 20'h00007, 1'b0, none);
        // Range boundary, then an unmapped register write that must be ignored.
        plan_write(lecd_pkg::CFG_ELEMENT_COUNT, 21'h080000);
        plan_access(MODE_GET, 20'h80000, 1'b1, out_of_range);
        plan_write(CFG_UNMAPPED, '0);
        plan_access(MODE_GET, 20'h7FFFF, 1'b0, none);

        foreach (access_plan[i])
        begin
            if (access_plan[i].is_cfg)
                write_reg(access_plan[i].reg_sel, access_plan[i].reg_data);
            else
                issue_access(access_plan[i].m, access_plan[i].idx, access_plan[i].pinned,
                             access_plan[i].want);
        end

        // Random phases. Most accesses hit a small working set a few entries
        // larger than the capacity, so hits, fills and evictions all occur;
        // the rest are wide random indices, range-boundary indices and the
        // index extremes. Phase 3 runs with no random idling on either side.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            calm <= (ph == 3);
            write_reg(lecd_pkg::CFG_ELEMENT_COUNT, lecd_pkg::CFG_DATA_W'(phase_ec[ph]));
            cap_word = lecd_pkg::CFG_DATA_W'($urandom);
            cap_word[lecd_pkg::CAPACITY_W-1:0] = lecd_pkg::CAPACITY_W'(phase_cap[ph]);
            write_reg(lecd_pkg::CFG_CAPACITY, cap_word);

            eff    = (phase_cap[ph] == 0) ? 1 :
                     (phase_cap[ph] > ENTRIES) ? ENTRIES : phase_cap[ph];
            span   = (phase_ec[ph] > (1 << INDEX_BITS)) ? (1 << INDEX_BITS) : phase_ec[ph];
            pool_n = eff + 4;
            base   = (span > pool_n) ? $urandom_range(span - pool_n) : 0;

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 72)
                    idx = INDEX_BITS'(base + $urandom_range(pool_n - 1));
                else if (pick < 84)
                    idx = INDEX_BITS'($urandom);
                else if (pick < 92)
                    idx = INDEX_BITS'(int'(phase_ec[ph]) + int'($urandom_range(2)) - 1);
                else
                    idx = $urandom_range(1) ? '1 : '0;
                issue_access(($urandom_range(99) < PUT_PERCENT) ? MODE_PUT : MODE_GET, idx,
                             1'b0, none);
            end
        end

        // Wind down: drop valid, collect every result, then a quiet spell
        // long enough to catch any stray extra result.
        in_valid <= 1'b0;
        while (n_results != n_sent)
            @(posedge clk);
        repeat (4 * ENTRIES) @(posedge clk);

        if (pending_results.size() != 0)
        begin
            $display("%0d expected results never arrived", pending_results.size());
            n_fail += pending_results.size();
        end

        $display("%0d accesses over %0d register writes: %0d hits, %0d fills, %0d evictions,",
                 n_sent, n_writes, n_hits, n_fills, n_evicts);
        $display("%0d puts, %0d out of range; %0d check failures", n_puts, n_oor, n_fail);
        if (n_fail == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // A typical run takes about 0.3 ms and the slowest legal one stays under
    // 1 ms; give it 5 ms.
    initial
    begin : watchdog
        #5_000_000;
        $display("timeout: %0d accesses sent, %0d results back", n_sent, n_results);
        $display("== FAIL ==");
        $finish;
    end

endmodule
